// ===== design/cbam_pkg.sv =====
// Package for the cell block average monitor: item structs, register
// indexes, divider request and response types and the state enum.
// No dependencies.
package cbam_pkg;

  localparam int VSUM_W    = 24;
  localparam int TSUM_W    = 16;
  localparam int LEN_W     = 8;
  localparam int DIV_STEPS = VSUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int T_FIRST   = VSUM_W - TSUM_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_AVG_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_T_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_T_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_V_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_V_LOW   = 3'd4;

  localparam logic [LEN_W-1:0]  AVG_LEN_RST = 8'd8;
  localparam logic signed [7:0] T_HIGH_RST  = 8'sd60;
  localparam logic signed [7:0] T_LOW_RST   = -8'sd20;
  localparam logic [15:0]       V_HIGH_RST  = 16'd4300;
  localparam logic [15:0]       V_LOW_RST   = 16'd2500;

  typedef struct packed {
    logic [15:0]       voltage_mv;
    logic signed [7:0] temperature_c;
  } cbam_in_t;

  typedef struct packed {
    logic [15:0]       avg_voltage_mv;
    logic signed [7:0] avg_temperature_c;
    logic              avg_updated;
    logic              volt_high_warn;
    logic              volt_low_warn;
    logic              temp_high_warn;
    logic              temp_low_warn;
  } cbam_out_t;

  typedef struct packed {
    logic              start;
    logic [LEN_W-1:0]  len;
    logic [VSUM_W-1:0] v_dividend;
    logic [TSUM_W-1:0] t_mag;
  } cbam_div_req_t;

  typedef struct packed {
    logic              done;
    logic [VSUM_W-1:0] v_quot;
    logic [TSUM_W-1:0] t_quot;
  } cbam_div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } cbam_state_t;

endpackage

// ===== design/cbam_div.sv =====
// Bit-serial restoring divider: voltage sum and temperature magnitude are
// both divided by the average length, one quotient bit per cycle.
// Depends on cbam_pkg.
module cbam_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cbam_pkg::cbam_div_req_t req,
  output cbam_pkg::cbam_div_rsp_t rsp
);
  import cbam_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [LEN_W-1:0]  len_r;
  logic [VSUM_W-1:0] vq_r;
  logic [LEN_W-1:0]  vrem_r;
  logic [TSUM_W-1:0] tq_r;
  logic [LEN_W-1:0]  trem_r;

  logic [LEN_W:0]    v_trial, v_diff, t_trial, t_diff;
  logic              v_ge, t_ge, t_active, last_step;

  always_comb begin
    v_trial   = {vrem_r, vq_r[VSUM_W-1]};
    v_diff    = v_trial - {1'b0, len_r};
    v_ge      = v_trial >= {1'b0, len_r};
    t_trial   = {trem_r, tq_r[TSUM_W-1]};
    t_diff    = t_trial - {1'b0, len_r};
    t_ge      = t_trial >= {1'b0, len_r};
    t_active  = step_r >= STEP_W'(T_FIRST);
    last_step = step_r == STEP_W'(DIV_STEPS - 1);
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + STEP_W'(1);
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // The temperature dividend is eight bits shorter, so it joins in late.
  always_ff @(posedge clk) begin
    if (req.start) begin
      len_r  <= req.len;
      vq_r   <= req.v_dividend;
      vrem_r <= '0;
      tq_r   <= req.t_mag;
      trem_r <= '0;
    end else if (busy_r) begin
      vq_r   <= {vq_r[VSUM_W-2:0], v_ge};
      vrem_r <= v_ge ? v_diff[LEN_W-1:0] : v_trial[LEN_W-1:0];
      if (t_active) begin
        tq_r   <= {tq_r[TSUM_W-2:0], t_ge};
        trem_r <= t_ge ? t_diff[LEN_W-1:0] : t_trial[LEN_W-1:0];
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.v_quot = vq_r;
  assign rsp.t_quot = tq_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r && req.len != '0)
    else $error("divider started while busy or with zero divisor");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> vrem_r < len_r && trem_r < len_r)
    else $error("divider remainder not below divisor");

  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && last_step && !req.start |=> done_r && !busy_r)
    else $error("divider did not finish after its last step");

endmodule

// ===== design/cell_block_average_monitor.sv =====
// Cell block average monitor. A sample that does not close an average goes
// from the idle state to the push state, which registers the result item once
// the output is free; no new item is accepted before that. A sample that
// closes an average first runs the 24-step bit-serial divider, then pushes.
// Synchronous active-low reset restores the register defaults and clears sums,
// averages and flags. Depends on cbam_pkg and cbam_div.
module cell_block_average_monitor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cbam_pkg::cbam_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cbam_pkg::cbam_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbam_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cbam_pkg::*;

  cbam_state_t       state_r, state_nxt;
  logic [LEN_W-1:0]  avg_len_r;
  logic signed [7:0] t_high_r, t_low_r;
  logic [15:0]       v_high_r, v_low_r;

  logic              seeded_r;
  logic [VSUM_W-1:0] vsum_r;
  logic [TSUM_W-1:0] tsum_r;
  logic [LEN_W-1:0]  count_r;
  logic [15:0]       avg_v_r;
  logic signed [7:0] avg_t_r;
  logic [3:0]        flags_r, flags_nxt;
  logic              upd_r;
  logic              tneg_r;
  logic              out_valid_r;
  cbam_out_t         out_r;

  logic              accept, complete, out_load;
  logic [LEN_W-1:0]  len_eff, count_inc;
  logic [VSUM_W-1:0] vsum_add;
  logic [TSUM_W-1:0] tsum_add, tsum_mag;
  logic [15:0]       v_avg_sat;
  logic signed [7:0] t_avg_sat;
  cbam_div_req_t     div_req;
  cbam_div_rsp_t     div_rsp;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    len_eff   = (avg_len_r == '0) ? LEN_W'(1) : avg_len_r;
    vsum_add  = vsum_r + {8'd0, in_data.voltage_mv};
    tsum_add  = tsum_r + {{8{in_data.temperature_c[7]}}, in_data.temperature_c};
    count_inc = count_r + LEN_W'(1);
    complete  = count_inc >= len_eff;
    tsum_mag  = tsum_add[TSUM_W-1] ? (~tsum_add + TSUM_W'(1)) : tsum_add;

    flags_nxt = flags_r;
    if (in_data.temperature_c > t_high_r) flags_nxt[2] = 1'b1;
    else if (in_data.temperature_c < t_low_r) flags_nxt[3] = 1'b1;
    if (in_data.voltage_mv > v_high_r) flags_nxt[0] = 1'b1;
    else if (in_data.voltage_mv < v_low_r) flags_nxt[1] = 1'b1;

    // Quotients overflow only when the length was lowered mid-block.
    v_avg_sat = (|div_rsp.v_quot[VSUM_W-1:16]) ? 16'hFFFF : div_rsp.v_quot[15:0];
    if (!tneg_r) begin
      t_avg_sat = (div_rsp.t_quot > TSUM_W'(127)) ? 8'sd127
                                                   : signed'(div_rsp.t_quot[7:0]);
    end else begin
      t_avg_sat = (div_rsp.t_quot > TSUM_W'(128)) ? 8'h80
                                                   : signed'(~div_rsp.t_quot[7:0] + 8'd1);
    end
  end

  always_comb begin
    state_nxt          = state_r;
    in_ready           = 1'b0;
    out_load           = 1'b0;
    div_req.start      = 1'b0;
    div_req.len        = len_eff;
    div_req.v_dividend = vsum_add;
    div_req.t_mag      = tsum_mag;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (seeded_r && complete) begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  cbam_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      avg_len_r   <= AVG_LEN_RST;
      t_high_r    <= T_HIGH_RST;
      t_low_r     <= T_LOW_RST;
      v_high_r    <= V_HIGH_RST;
      v_low_r     <= V_LOW_RST;
      seeded_r    <= 1'b0;
      vsum_r      <= '0;
      tsum_r      <= '0;
      count_r     <= '0;
      avg_v_r     <= '0;
      avg_t_r     <= '0;
      flags_r     <= '0;
      upd_r       <= 1'b0;
      tneg_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_AVG_LEN: avg_len_r <= cfg_data[LEN_W-1:0];
          CFG_T_HIGH:  t_high_r  <= signed'(cfg_data[7:0]);
          CFG_T_LOW:   t_low_r   <= signed'(cfg_data[7:0]);
          CFG_V_HIGH:  v_high_r  <= cfg_data;
          CFG_V_LOW:   v_low_r   <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (!seeded_r) begin
          seeded_r <= 1'b1;
          avg_v_r  <= in_data.voltage_mv;
          avg_t_r  <= in_data.temperature_c;
          upd_r    <= 1'b0;
        end else begin
          flags_r <= flags_nxt;
          upd_r   <= complete;
          tneg_r  <= tsum_add[TSUM_W-1];
          if (complete) begin
            vsum_r  <= '0;
            tsum_r  <= '0;
            count_r <= '0;
          end else begin
            vsum_r  <= vsum_add;
            tsum_r  <= tsum_add;
            count_r <= count_inc;
          end
        end
      end
      if (div_rsp.done) begin
        avg_v_r <= v_avg_sat;
        avg_t_r <= t_avg_sat;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.avg_voltage_mv    <= avg_v_r;
      out_r.avg_temperature_c <= avg_t_r;
      out_r.avg_updated       <= upd_r;
      out_r.volt_high_warn    <= flags_r[0];
      out_r.volt_low_warn     <= flags_r[1];
      out_r.temp_high_warn    <= flags_r[2];
      out_r.temp_low_warn     <= flags_r[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '1)
    else $error("sample count reached its maximum without closing an average");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUSH && out_valid_r && !out_ready |=> state_r == ST_PUSH)
    else $error("result item overwrote one not yet taken");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for cell_block_average_monitor: a queue-fed driver,
// a checking monitor and a predictor of the averages and sticky warning flags.
// Depends on cbam_pkg and the design under test.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cbam_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_ITEMS    = 60;
  localparam int END_WAIT       = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  cbam_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  cbam_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cell_block_average_monitor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Register shadows
  logic [LEN_W-1:0]  len_reg    = AVG_LEN_RST;
  logic signed [7:0] t_high_reg = T_HIGH_RST;
  logic signed [7:0] t_low_reg  = T_LOW_RST;
  logic [15:0]       v_high_reg = V_HIGH_RST;
  logic [15:0]       v_low_reg  = V_LOW_RST;

  // Predicted block state
  logic              is_seeded  = 1'b0;
  logic [VSUM_W-1:0] vsum_acc   = '0;
  int                tsum_acc   = 0;
  logic [LEN_W-1:0]  sample_cnt = '0;
  logic [15:0]       avg_v_now  = '0;
  logic signed [7:0] avg_t_now  = '0;
  logic              warn_vh = 1'b0, warn_vl = 1'b0, warn_th = 1'b0, warn_tl = 1'b0;

  cbam_in_t  sample_q[$];
  cbam_out_t expected_q[$];

  int err_count     = 0;
  int samples_sent  = 0;
  int results_seen  = 0;
  int averages_seen = 0;
  int cfg_writes    = 0;
  int idle_cycles   = 0;

  int burst_left = 1;
  int gap_left   = 0;
  int ready_left = 0;

  function automatic cbam_out_t predict_sample(input cbam_in_t s);
    cbam_out_t   r;
    int unsigned len;
    int unsigned av;
    int          at;
    logic        updated;
    updated = 1'b0;
    if (!is_seeded) begin
      // The seeding sample only loads the averages.
      is_seeded = 1'b1;
      avg_v_now = s.voltage_mv;
      avg_t_now = s.temperature_c;
    end else begin
      len = (len_reg == 0) ? 1 : len_reg;
      vsum_acc   = vsum_acc + s.voltage_mv;
      tsum_acc   = tsum_acc + s.temperature_c;
      sample_cnt = sample_cnt + 1'b1;
      if (sample_cnt >= len) begin
        av = vsum_acc / len;
        at = tsum_acc / int'(len);
        if (av > 65535) av = 65535;
        if (at > 127) at = 127;
        if (at < -128) at = -128;
        avg_v_now  = av[15:0];
        avg_t_now  = at[7:0];
        vsum_acc   = '0;
        tsum_acc   = 0;
        sample_cnt = '0;
        updated    = 1'b1;
      end
      if (s.temperature_c > t_high_reg) warn_th = 1'b1;
      else if (s.temperature_c < t_low_reg) warn_tl = 1'b1;
      if (s.voltage_mv > v_high_reg) warn_vh = 1'b1;
      else if (s.voltage_mv < v_low_reg) warn_vl = 1'b1;
    end
    r.avg_voltage_mv    = avg_v_now;
    r.avg_temperature_c = avg_t_now;
    r.avg_updated       = updated;
    r.volt_high_warn    = warn_vh;
    r.volt_low_warn     = warn_vl;
    r.temp_high_warn    = warn_th;
    r.temp_low_warn     = warn_tl;
    return r;
  endfunction

  function automatic void note_error(input string what, input int want_v, input int got_v);
    err_count++;
    if (err_count <= 10)
      $display("MISMATCH at result %0d, %s: expected %0d, got %0d",
               results_seen, what, want_v, got_v);
  endfunction

  task automatic check_result(input cbam_out_t got);
    cbam_out_t want;
    if (expected_q.size() == 0) begin
      note_error("result with no sample waiting", 0, 1);
      return;
    end
    want = expected_q.pop_front();
    if (got.avg_voltage_mv !== want.avg_voltage_mv)
      note_error("avg_voltage_mv", int'(want.avg_voltage_mv), int'(got.avg_voltage_mv));
    if (got.avg_temperature_c !== want.avg_temperature_c)
      note_error("avg_temperature_c", int'(want.avg_temperature_c),
                 int'(got.avg_temperature_c));
    if (got.avg_updated !== want.avg_updated)
      note_error("avg_updated", int'(want.avg_updated), int'(got.avg_updated));
    if (got.volt_high_warn !== want.volt_high_warn)
      note_error("volt_high_warn", int'(want.volt_high_warn), int'(got.volt_high_warn));
    if (got.volt_low_warn !== want.volt_low_warn)
      note_error("volt_low_warn", int'(want.volt_low_warn), int'(got.volt_low_warn));
    if (got.temp_high_warn !== want.temp_high_warn)
      note_error("temp_high_warn", int'(want.temp_high_warn), int'(got.temp_high_warn));
    if (got.temp_low_warn !== want.temp_low_warn)
      note_error("temp_low_warn", int'(want.temp_low_warn), int'(got.temp_low_warn));
  endtask

  // Driver: bursts of items separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_sample(in_data));
        samples_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (sample_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= sample_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result; ready follows its own run and stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.avg_updated === 1'b1) averages_seen++;
        check_result(out_data);
      end
      if (ready_left != 0) begin
        ready_left <= ready_left - 1;
      end else if (!out_ready) begin
        out_ready  <= 1'b1;
        ready_left <= $urandom_range(1, 60);
      end else if ($urandom_range(0, 3) == 0) begin
        ready_left <= $urandom_range(1, 60);
      end else begin
        out_ready  <= 1'b0;
        ready_left <= $urandom_range(0, 14);
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired: %0d samples still pending, %0d results outstanding",
               sample_q.size(), expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_AVG_LEN: len_reg    = val[7:0];
      CFG_T_HIGH:  t_high_reg = val[7:0];
      CFG_T_LOW:   t_low_reg  = val[7:0];
      CFG_V_HIGH:  v_high_reg = val;
      CFG_V_LOW:   v_low_reg  = val;
      default: ;
    endcase
  endtask

  // Holds off until every queued item has been taken and answered.
  task automatic drain();
    while (sample_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic queue_sample(input logic [15:0] v, input logic signed [7:0] t);
    cbam_in_t s;
    s.voltage_mv    = v;
    s.temperature_c = t;
    sample_q.push_back(s);
  endtask

  task automatic write_random_config();
    logic [7:0] len;
    case ($urandom_range(0, 9))
      0:       len = 8'd0;
      1:       len = 8'd1;
      2:       len = 8'd255;
      3:       len = 8'($urandom_range(1, 255));
      default: len = 8'($urandom_range(2, 12));
    endcase
    write_reg(CFG_AVG_LEN, {8'($urandom()), len});
    write_reg(CFG_T_HIGH, 16'($urandom()));
    write_reg(CFG_T_LOW, 16'($urandom()));
    write_reg(CFG_V_HIGH, 16'($urandom()));
    write_reg(CFG_V_LOW, 16'($urandom()));
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_V_LOW + 3'($urandom_range(1, 3)), 16'($urandom()));
  endtask

  initial begin
    logic [15:0]       v;
    logic signed [7:0] t;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the seed is out of limits but must leave the flags
    // alone; the rest sit on or inside the limits and close one average.
    queue_sample(16'd65535, -8'sd128);
    queue_sample(16'd4300, 8'sd60);
    queue_sample(16'd2500, -8'sd20);
    queue_sample(16'd3000, 8'sd0);
    queue_sample(16'd4299, 8'sd59);
    queue_sample(16'd2501, -8'sd19);
    queue_sample(16'd3700, 8'sd25);
    queue_sample(16'd4300, -8'sd20);
    queue_sample(16'd2500, 8'sd60);
    drain();

    // Zero length acts as one. High limits below low limits show that the
    // high check wins; the unused indexes must change nothing.
    write_reg(CFG_AVG_LEN, 16'hA500);
    write_reg(CFG_T_HIGH, 16'h5ACE);
    write_reg(CFG_T_LOW, 16'hC332);
    write_reg(CFG_V_HIGH, 16'd1000);
    write_reg(CFG_V_LOW, 16'd3000);
    write_reg(CFG_V_LOW + 3'd1, 16'h0000);
    write_reg(CFG_V_LOW + 3'd3, 16'hFFFF);
    queue_sample(16'd2000, 8'sd0);
    queue_sample(16'd500, -8'sd100);
    queue_sample(16'd65535, 8'sd127);
    queue_sample(16'd0, -8'sd128);
    drain();

    // Lowering the length part way through a block drives the averages into
    // saturation: voltage top and temperature bottom first, then temperature top.
    write_reg(CFG_AVG_LEN, 16'h00FF);
    write_reg(CFG_T_HIGH, 16'hFF7F);
    write_reg(CFG_T_LOW, 16'h0180);
    write_reg(CFG_V_HIGH, 16'd65535);
    write_reg(CFG_V_LOW, 16'd0);
    queue_sample(16'd65535, -8'sd128);
    queue_sample(16'd65535, -8'sd128);
    drain();
    write_reg(CFG_AVG_LEN, 16'h0001);
    queue_sample(16'd65535, -8'sd128);
    drain();
    write_reg(CFG_AVG_LEN, 16'h00FF);
    queue_sample(16'd40000, 8'sd127);
    queue_sample(16'd40000, 8'sd127);
    drain();
    write_reg(CFG_AVG_LEN, 16'h0002);
    queue_sample(16'd40000, 8'sd127);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_random_config();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 7))
          0:       v = 16'd0;
          1:       v = 16'd65535;
          2:       v = v_high_reg + 16'($urandom_range(0, 4)) - 16'd2;
          default: v = 16'($urandom());
        endcase
        case ($urandom_range(0, 7))
          0:       t = -8'sd128;
          1:       t = 8'sd127;
          default: t = 8'($urandom());
        endcase
        queue_sample(v, t);
      end
      drain();
    end

    repeat (END_WAIT) @(posedge clk);
    if (expected_q.size() != 0) note_error("results never delivered", 0, expected_q.size());

    $display("Covered %0d samples and %0d results, %0d of them closing an average.",
             samples_sent, results_seen, averages_seen);
    $display("Made %0d register writes, lengths of zero, one and 255 among them.", cfg_writes);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cbam_pkg.sv
design/cbam_div.sv
design/cell_block_average_monitor.sv
dv/tb_top.sv
